/* rtl/rqdo_pkg.sv */
// Shared types, field widths and command codes for the report queue.
package rqdo_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int MAX_REPORT_DEF  = 64;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PW    = $clog2(CMDQ_DEPTH);

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PROTO = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  limit;
        logic              boot;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [LEN_W-1:0]  taken_length;
        logic              final_res;
        logic              empty_res;
        logic              notice;
    } t_res;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TAKE  = 2'd1,
        OP_PROTO = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  limit;
        logic              boot;
    } t_cmd;

endpackage

/* rtl/rqdo_front.sv */
// Request intake: accept, decode kind, clamp take limit, drop unused kinds.
module rqdo_front #(
    parameter int MAX_REPORT = rqdo_pkg::MAX_REPORT_DEF
) (
    input  logic           start,
    input  rqdo_pkg::t_req i_req,
    input  logic           i_full,
    output logic           busy,
    output logic           o_push,
    output rqdo_pkg::t_cmd o_cmd
);
    import rqdo_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LIM = LEN_W'(MAX_REPORT);

    logic accept;
    logic known;

    assign busy   = i_full;
    assign accept = start && !i_full;

    always_comb begin
        o_cmd.data  = i_req.data;
        o_cmd.last  = i_req.last;
        o_cmd.boot  = i_req.boot;
        o_cmd.limit = (i_req.limit > MAX_LIM) ? MAX_LIM : i_req.limit;
        known       = 1'b1;
        case (i_req.kind)
            KIND_BYTE:  o_cmd.op = OP_BYTE;
            KIND_TAKE:  o_cmd.op = OP_TAKE;
            KIND_PROTO: o_cmd.op = OP_PROTO;
            default: begin
                // drop the unused kind, it has no effect
                o_cmd.op = OP_BYTE;
                known    = 1'b0;
            end
        endcase
    end

    assign o_push = accept && known;

endmodule

/* rtl/rqdo_cmdq.sv */
// Short command queue between the intake and the execution back end.
module rqdo_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rqdo_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output rqdo_pkg::t_cmd o_cmd
);
    import rqdo_pkg::*;

    t_cmd                 r_mem [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CMDQ_PW:0]     r_count,  n_count;
    logic                 do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (CMDQ_PW+1)'(CMDQ_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == CMDQ_PW'(CMDQ_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CMDQ_PW'(CMDQ_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

/* rtl/rqdo_back.sv */
// Execution back end: report store, slot ring bookkeeping, take streaming.
module rqdo_back #(
    parameter int QUEUE_DEPTH = rqdo_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_REPORT  = rqdo_pkg::MAX_REPORT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  rqdo_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_strobe,
    output rqdo_pkg::t_res o_res
);
    import rqdo_pkg::*;

    localparam int SW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int LW    = $clog2(MAX_REPORT + 1);
    localparam int MEM_D = QUEUE_DEPTH * MAX_REPORT;
    localparam int AW    = $clog2(MEM_D);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LEN    = 3'b010,
        S_STREAM = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_head,  n_head;
    logic [CW-1:0]       r_count, n_count;
    logic [LW-1:0]       r_wi,    n_wi;
    logic                r_writing, n_writing;
    logic                r_boot,  n_boot;
    logic [LW-1:0]       r_limit, n_limit;
    logic [LW-1:0]       r_len,   n_len;
    logic [LW-1:0]       r_idx,   n_idx;
    logic [AW-1:0]       r_base,  n_base;
    logic                r_out_valid, n_out_valid;
    t_res                r_out,   n_out;

    logic [BYTE_W-1:0]   r_bytes [MEM_D];
    logic [LW-1:0]       r_lens  [QUEUE_DEPTH];
    logic [BYTE_W-1:0]   r_byte_rd;
    logic [LW-1:0]       r_len_rd;

    logic                byte_we;
    logic [AW-1:0]       byte_wa;
    logic [AW-1:0]       byte_ra;
    logic                len_we;
    logic [SW-1:0]       len_wa;
    logic [LW-1:0]       len_wd;

    always_comb begin
        logic [SW-1:0] h;
        logic [CW-1:0] c;
        logic [LW-1:0] wi;
        logic [SW:0]   s;
        logic [SW-1:0] slot;
        logic [LW-1:0] len;
        logic          fin;

        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_wi        = r_wi;
        n_writing   = r_writing;
        n_boot      = r_boot;
        n_limit     = r_limit;
        n_len       = r_len;
        n_idx       = r_idx;
        n_base      = r_base;
        n_out_valid = 1'b0;
        n_out       = '0;
        o_pop       = 1'b0;
        byte_we     = 1'b0;
        byte_wa     = '0;
        byte_ra     = '0;
        len_we      = 1'b0;
        len_wa      = '0;
        len_wd      = '0;
        h           = r_head;
        c           = r_count;
        wi          = r_wi;
        s           = '0;
        slot        = '0;
        len         = '0;
        fin         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_BYTE: begin
                            if (!r_writing) begin
                                wi = '0;
                                // drop the oldest report to make room
                                if (r_count == CW'(QUEUE_DEPTH)) begin
                                    h = (r_head == SW'(QUEUE_DEPTH-1)) ? '0 : r_head + 1'b1;
                                    c = CW'(QUEUE_DEPTH-1);
                                end
                            end
                            s = (SW+1)'(h) + (SW+1)'(c);
                            if (s >= (SW+1)'(QUEUE_DEPTH)) begin
                                s = s - (SW+1)'(QUEUE_DEPTH);
                            end
                            slot = s[SW-1:0];
                            if (wi < LW'(MAX_REPORT)) begin
                                byte_we = 1'b1;
                                byte_wa = AW'(slot) * AW'(MAX_REPORT) + AW'(wi);
                                wi      = wi + 1'b1;
                            end
                            if (i_cmd.last) begin
                                len_we         = 1'b1;
                                len_wa         = slot;
                                len_wd         = wi;
                                c              = c + 1'b1;
                                n_writing      = 1'b0;
                                wi             = '0;
                                n_out_valid    = 1'b1;
                                n_out.notice   = 1'b1;
                            end else begin
                                n_writing = 1'b1;
                            end
                            n_head  = h;
                            n_count = c;
                            n_wi    = wi;
                        end
                        OP_TAKE: begin
                            if (r_count == '0) begin
                                n_out_valid     = 1'b1;
                                n_out.final_res = 1'b1;
                                n_out.empty_res = 1'b1;
                            end else begin
                                // head length is read this cycle
                                n_limit = i_cmd.limit[LW-1:0];
                                n_state = S_LEN;
                            end
                        end
                        OP_PROTO: begin
                            if (i_cmd.boot != r_boot) begin
                                n_boot    = i_cmd.boot;
                                n_head    = '0;
                                n_count   = '0;
                                n_writing = 1'b0;
                                n_wi      = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LEN: begin
                len     = (r_len_rd < r_limit) ? r_len_rd : r_limit;
                n_len   = len;
                n_base  = AW'(r_head) * AW'(MAX_REPORT);
                n_head  = (r_head == SW'(QUEUE_DEPTH-1)) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
                n_idx   = '0;
                if (len == '0) begin
                    n_out_valid     = 1'b1;
                    n_out.final_res = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    byte_ra = AW'(r_head) * AW'(MAX_REPORT);
                    n_state = S_STREAM;
                end
            end
            S_STREAM: begin
                fin                = (LW'(r_idx + 1'b1) == r_len);
                n_out_valid        = 1'b1;
                n_out.byte_out     = r_byte_rd;
                n_out.taken_length = LEN_W'(r_len);
                n_out.final_res    = fin;
                n_idx              = r_idx + 1'b1;
                byte_ra            = r_base + AW'(r_idx) + 1'b1;
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (byte_we) begin
            r_bytes[byte_wa] <= i_cmd.data;
        end
        r_byte_rd <= r_bytes[byte_ra];
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_lens[len_wa] <= len_wd;
        end
        r_len_rd <= r_lens[r_head];
    end

    always_ff @(posedge i_clk) begin
        r_limit <= n_limit;
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_base  <= n_base;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_wi        <= '0;
            r_writing   <= 1'b0;
            r_boot      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_wi        <= n_wi;
            r_writing   <= n_writing;
            r_boot      <= n_boot;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_res    = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queued count above queue depth");

    a_partial_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_writing |-> (r_count < CW'(QUEUE_DEPTH)))
        else $error("partial report without a free slot");

    a_stream_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_idx < r_len))
        else $error("stream index past taken length");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("command popped while a take is running");

    a_take_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEN) |=> (r_len <= LW'(MAX_REPORT)))
        else $error("taken length above maximum report size");

endmodule

/* rtl/report_queue_drop_oldest_core.sv */
// Top level of the drop-oldest report queue: intake, command queue, back end.
//
// Requests are taken at a clock edge with start high and busy low; busy rises
// only when the four-entry command queue is full, so a steady run of report
// bytes is absorbed at one per cycle while no take is running. The back end
// retires a report byte, a protocol request or an empty-queue take without
// leaving its idle state. A take on a non-empty queue clamps the head length
// and sets up the store read in S_LEN, then streams its bytes from S_STREAM;
// a take truncated to zero bytes ends in S_LEN. This follows from the single
// read port of the report byte store and the registered length store. Results
// leave through an output register in the cycle after the back end produces
// them, one per cycle, each marked by o_strobe for exactly one cycle; the
// receiver cannot hold them off. The last byte of a report yields a notice
// result. Report stores come up undefined and need no clearing after reset.
module report_queue_drop_oldest_core #(
    parameter int QUEUE_DEPTH = rqdo_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_REPORT  = rqdo_pkg::MAX_REPORT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rqdo_pkg::t_req i_req,
    output logic           busy,
    output logic           o_strobe,
    output rqdo_pkg::t_res o_res
);
    import rqdo_pkg::*;

    logic  push;
    t_cmd  front_cmd;
    logic  q_full;
    logic  q_valid;
    t_cmd  q_cmd;
    logic  pop;

    // decode and clamp incoming requests
    rqdo_front #(
        .MAX_REPORT (MAX_REPORT)
    ) u_front (
        .start  (start),
        .i_req  (i_req),
        .i_full (q_full),
        .busy   (busy),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    // hold decoded commands while a take streams
    rqdo_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    // execute commands against the report ring
    rqdo_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_REPORT  (MAX_REPORT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_res       (o_res)
    );

endmodule

/* sim/report_queue_drop_oldest_core_checker.sv */
// Checker for the report queue: tracks the queue state and compares every result.
`timescale 1ns / 1ps

module report_queue_drop_oldest_core_checker #(
    parameter int QUEUE_DEPTH = rqdo_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_REPORT  = rqdo_pkg::MAX_REPORT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  rqdo_pkg::t_req i_req,
    input  logic           i_strobe,
    input  rqdo_pkg::t_res i_res,
    output int             o_fail_count,
    output int             o_pending,
    output int             o_checked
);
    import rqdo_pkg::*;

    localparam int SHOWN_FAILS = 10;

    // Shadow copy of the queue contents and pointers.
    logic [BYTE_W-1:0] shadow_bytes [QUEUE_DEPTH*MAX_REPORT];
    logic [LEN_W-1:0]  shadow_len   [QUEUE_DEPTH];
    int unsigned       head_slot;
    int unsigned       queued;
    int unsigned       fill_idx;
    bit                filling;
    bit                boot_mode;

    t_res outbound_results[$];
    int   fails;
    int   checked;

    // Apply one request to the shadow queue and append the results it causes.
    task automatic step_report_queue(input t_req req);
        int unsigned slot;
        int unsigned lim;
        int unsigned len;
        t_res        res;
        res = '0;
        case (req.kind)
            KIND_BYTE: begin
                if (!filling) begin
                    if (queued >= QUEUE_DEPTH) begin
                        head_slot = (head_slot + 1) % QUEUE_DEPTH;
                        queued    = QUEUE_DEPTH - 1;
                    end
                    filling  = 1'b1;
                    fill_idx = 0;
                end
                slot = (head_slot + queued) % QUEUE_DEPTH;
                if (fill_idx < MAX_REPORT) begin
                    shadow_bytes[slot*MAX_REPORT + fill_idx] = req.data;
                    fill_idx++;
                end
                if (req.last) begin
                    shadow_len[slot] = LEN_W'(fill_idx);
                    queued++;
                    filling  = 1'b0;
                    fill_idx = 0;
                    res.notice = 1'b1;
                    outbound_results.push_back(res);
                end
            end
            KIND_TAKE: begin
                if (queued == 0) begin
                    res.final_res = 1'b1;
                    res.empty_res = 1'b1;
                    outbound_results.push_back(res);
                end else begin
                    slot = head_slot;
                    lim  = (req.limit > MAX_REPORT) ? MAX_REPORT : req.limit;
                    len  = shadow_len[slot];
                    if (len > MAX_REPORT) len = MAX_REPORT;
                    if (lim < len) len = lim;
                    head_slot = (head_slot + 1) % QUEUE_DEPTH;
                    queued--;
                    if (len == 0) begin
                        res.final_res = 1'b1;
                        outbound_results.push_back(res);
                    end else begin
                        for (int unsigned i = 0; i < len; i++) begin
                            res.byte_out     = shadow_bytes[slot*MAX_REPORT + i];
                            res.taken_length = LEN_W'(len);
                            res.final_res    = (i + 1 == len);
                            outbound_results.push_back(res);
                        end
                    end
                end
            end
            KIND_PROTO: begin
                // A request for the current protocol keeps everything, partial report too.
                if (req.boot != boot_mode) begin
                    boot_mode = req.boot;
                    head_slot = 0;
                    queued    = 0;
                    filling   = 1'b0;
                    fill_idx  = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_failure(input string what, input t_res want, input t_res got);
        fails++;
        if (fails <= SHOWN_FAILS)
            $display("[%0t] %s: byte %0h/%0h len %0d/%0d final %0b/%0b empty %0b/%0b notice %0b/%0b",
                     $realtime, what, want.byte_out, got.byte_out, want.taken_length,
                     got.taken_length, want.final_res, got.final_res, want.empty_res,
                     got.empty_res, want.notice, got.notice);
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            head_slot = 0;
            queued    = 0;
            fill_idx  = 0;
            filling   = 1'b0;
            boot_mode = 1'b0;
            outbound_results.delete();
        end else begin
            // Check the result leaving this cycle before booking the new request.
            if (i_strobe) begin
                checked++;
                if (outbound_results.size() == 0) begin
                    note_failure("unexpected result (expected/actual)", '0, i_res);
                end else begin
                    want = outbound_results.pop_front();
                    if (i_res.byte_out !== want.byte_out ||
                        i_res.taken_length !== want.taken_length ||
                        i_res.final_res !== want.final_res ||
                        i_res.empty_res !== want.empty_res ||
                        i_res.notice !== want.notice)
                        note_failure("result differs (expected/actual)", want, i_res);
                end
            end
            if (i_start && !i_busy)
                step_report_queue(i_req);
        end
        o_fail_count <= fails;
        o_pending    <= outbound_results.size();
        o_checked    <= checked;
    end

endmodule

/* sim/report_queue_drop_oldest_core_tb.sv */
// Testbench top: drives requests into the report queue and reports the verdict.
`timescale 1ns / 1ps

module report_queue_drop_oldest_core_tb;
    import rqdo_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int MAX_REPORT  = MAX_REPORT_DEF;
    // Kind code the block has no use for; it must be ignored.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PERCENT = 23;
    localparam int MIX_ITEMS    = 24;
    localparam int DRAIN_CYCLES = 80;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_res o_res;

    int fail_count;
    int pending;
    int checked;

    // Bookkeeping for the closing summary and for steering the stimulus.
    int kind_hits [4];
    int sent;
    bit idle_en  = 1'b1;
    bit cur_boot = 1'b0;

    report_queue_drop_oldest_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_REPORT (MAX_REPORT)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    report_queue_drop_oldest_core_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_REPORT (MAX_REPORT)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_strobe    (o_strobe),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or a result never shows up.
    initial begin
        #2_000_000;
        $display("report_queue_drop_oldest_core: mismatch");
        $finish;
    end

    // Build a request; fields the kind does not use carry random junk.
    function automatic t_req make_req(input logic [KIND_W-1:0] kind,
                                      input logic [BYTE_W-1:0] data,
                                      input logic last,
                                      input logic [LEN_W-1:0] limit,
                                      input logic boot);
        t_req r;
        r.kind  = kind;
        r.data  = data;
        r.last  = last;
        r.limit = limit;
        r.boot  = boot;
        return r;
    endfunction

    // Hand one request to the block: maybe idle first, then hold start until
    // an edge sees busy low.
    task automatic send_req(input t_req r);
        while (idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start <= 1'b0;
            i_req <= t_req'($bits(t_req)'($urandom));
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        kind_hits[r.kind]++;
        sent++;
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] data, input logic last);
        send_req(make_req(KIND_BYTE, data, last, LEN_W'($urandom), 1'($urandom)));
    endtask

    task automatic take_head(input logic [LEN_W-1:0] limit);
        send_req(make_req(KIND_TAKE, BYTE_W'($urandom), 1'($urandom), limit, 1'($urandom)));
    endtask

    task automatic set_proto(input logic boot);
        send_req(make_req(KIND_PROTO, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom),
                          boot));
        cur_boot = boot;
    endtask

    task automatic send_unused();
        send_req(make_req(KIND_UNUSED, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom),
                          1'($urandom)));
    endtask

    // Mostly short limits, some anywhere in the 7-bit range, some exactly full size.
    function automatic logic [LEN_W-1:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return LEN_W'($urandom_range(0, 10));
        if (sel < 85) return LEN_W'($urandom_range(0, 127));
        return LEN_W'(MAX_REPORT);
    endfunction

    // Stream one complete report; with mixed set, occasionally slip a take,
    // a same-protocol request or an unused kind between its bytes.
    task automatic send_report(input int len, input bit mixed);
        for (int i = 0; i < len; i++) begin
            put_byte(BYTE_W'($urandom), i == len - 1);
            if (mixed && i < len - 1 && $urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 2))
                    0: take_head(pick_limit());
                    1: set_proto(cur_boot);
                    default: send_unused();
                endcase
            end
        end
    endtask

    initial begin
        int mix_base;
        int sel;
        int junk_len;

        foreach (kind_hits[k]) kind_hits[k] = 0;
        sent = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty take, byte extremes, full, zero and over-range limits,
        // truncation, the unused kind, takes and protocol requests mid-report.
        take_head(7'd5);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'hA5, 1'b1);
        take_head(7'd64);
        put_byte(8'h5A, 1'b0);
        put_byte(8'h3C, 1'b1);
        take_head(7'd0);
        put_byte(8'h81, 1'b1);
        take_head(7'd127);
        send_unused();
        put_byte(8'h01, 1'b0);
        set_proto(1'b0);
        put_byte(8'h7E, 1'b1);
        take_head(7'd1);
        put_byte(8'h11, 1'b1);
        put_byte(8'hC3, 1'b0);
        take_head(7'd3);
        put_byte(8'h99, 1'b1);
        put_byte(8'h42, 1'b0);
        set_proto(1'b1);
        take_head(7'd64);

        // Oversize report on a freshly flushed queue, read back up to the maximum report size.
        // Hold start steady through the whole report.
        set_proto(~cur_boot);
        idle_en = 1'b0;
        send_report(MAX_REPORT + $urandom_range(1, 2), 1'b0);
        idle_en = 1'b1;
        take_head(7'd127);

        // Overfill so the oldest reports get dropped.
        repeat (QUEUE_DEPTH + 2) send_report($urandom_range(1, 2), 1'b0);

        // Random mix: mostly complete reports and takes, some noise and
        // reports cut short by a protocol switch.
        mix_base = sent;
        while (sent - mix_base < MIX_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                send_report($urandom_range(1, 6), 1'b1);
            end else if (sel < 80) begin
                take_head(pick_limit());
            end else if (sel < 87) begin
                set_proto(1'($urandom));
            end else if (sel < 92) begin
                send_unused();
            end else begin
                junk_len = $urandom_range(1, 4);
                repeat (junk_len) put_byte(BYTE_W'($urandom), 1'b0);
                set_proto(~cur_boot);
            end
        end
        idle_en = 1'b1;
        start <= 1'b0;

        // Drain: wait for every booked result, then give stragglers a chance.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d report bytes, %0d takes, %0d protocol, %0d unused.",
                 sent, kind_hits[KIND_BYTE], kind_hits[KIND_TAKE], kind_hits[KIND_PROTO],
                 kind_hits[KIND_UNUSED]);
        $display("Checked %0d results; %0d failures.", checked, fail_count);
        if (fail_count == 0)
            $display("report_queue_drop_oldest_core: match");
        else
            $display("report_queue_drop_oldest_core: mismatch");
        $finish;
    end

endmodule

/* files.f */
rtl/rqdo_pkg.sv
rtl/rqdo_front.sv
rtl/rqdo_cmdq.sv
rtl/rqdo_back.sv
rtl/report_queue_drop_oldest_core.sv
sim/report_queue_drop_oldest_core_checker.sv
sim/report_queue_drop_oldest_core_tb.sv
